/* rtl/mshc_pkg.sv */
`default_nettype none

package mshc_pkg;

  localparam int unsigned MSG_BITS = 11;
  localparam int unsigned CSUM_BITS = 4;
  localparam logic [3:0] HDR_BYTES = 4'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_FLAG_CLEAR = 3'd2;
  localparam logic [2:0] ST_BAD_CSUM = 3'd3;
  localparam logic [2:0] ST_BAD_PARITY = 3'd4;

  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_PARSE = 1'b1;

  // x^(14-i) mod x^4+x+1, one entry per message bit i (bit 0 is highest degree)
  localparam logic [CSUM_BITS-1:0] CSUM_SYN [MSG_BITS] = '{
    4'h9, 4'hD, 4'hF, 4'hE, 4'h7, 4'hA, 4'h5, 4'hB, 4'hC, 4'h6, 4'h3
  };

  typedef struct packed {
    logic        req_type;
    logic [7:0]  new_mode_id;
    logic [15:0] phr_in;
    logic [3:0]  byte_count;
  } in_t;

  typedef struct packed {
    logic [15:0] phr_out;
    logic [7:0]  mode_id_out;
    logic [2:0]  status;
  } out_t;

  // Remainder is linear in the message, so sum the per-bit syndromes.
  function automatic logic [CSUM_BITS-1:0] hdr_checksum(input logic [MSG_BITS-1:0] msg);
    logic [CSUM_BITS-1:0] rem;
    rem = '0;
    for (int i = 0; i < MSG_BITS; i++) begin
      if (msg[i]) begin
        rem = rem ^ CSUM_SYN[i];
      end
    end
    return rem;
  endfunction

endpackage

`default_nettype wire

/* rtl/mshc_codec.sv */
`default_nettype none

module mshc_codec (
  input  mshc_pkg::in_t  req,
  output mshc_pkg::out_t res
);
  import mshc_pkg::*;

  logic [CSUM_BITS-1:0] build_cs;
  logic [14:0]          build_body;
  logic [CSUM_BITS-1:0] rx_cs;

  assign build_cs   = hdr_checksum({req.new_mode_id, 2'b00, 1'b1});
  assign build_body = {build_cs, req.new_mode_id, 2'b00, 1'b1};
  assign rx_cs      = hdr_checksum(req.phr_in[MSG_BITS-1:0]);

  always_comb begin
    res.phr_out     = '0;
    res.mode_id_out = '0;
    res.status      = ST_OK;
    if (req.req_type == REQ_BUILD) begin
      res.phr_out = {^build_body, build_body};
    end else if (req.byte_count != HDR_BYTES) begin
      res.status = ST_BAD_LENGTH;
    end else if (!req.phr_in[0]) begin
      res.status = ST_FLAG_CLEAR;
    end else if (rx_cs != req.phr_in[14:11]) begin
      res.status = ST_BAD_CSUM;
    end else if ((^req.phr_in[14:0]) != req.phr_in[15]) begin
      res.status = ST_BAD_PARITY;
    end else begin
      res.mode_id_out = req.phr_in[10:3];
    end
  end

endmodule

`default_nettype wire

/* rtl/mode_switch_header_codec.sv */
// Mode-switch PHY header codec. Each input transfer either builds a 16-bit
// mode-switch header from a PHY mode id (flag set, reserved bits zero, BCH
// checksum over bits 0-10 in bits 11-14, odd-count parity in bit 15) or
// parses a received header and checks, in order, length of 2 bytes, flag,
// checksum and parity; status reports the first failure and the mode id is
// returned only when all checks pass. Byte 0 of the header is bits 7:0.
// One result transfer follows every input transfer, in order. The block
// accepts one header per cycle while the output is not stalled; each
// header passes through an input register, then a result register
// around the combinational codec logic. Output stalls hold both stages.
`default_nettype none

module mode_switch_header_codec (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  mshc_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output mshc_pkg::out_t out_data
);
  import mshc_pkg::*;

  // input stage
  logic in_valid_r;
  in_t  in_data_r;
  // result stage
  logic out_valid_r;
  out_t out_data_r;

  out_t codec_res;
  logic out_adv;
  logic in_adv;

  // Advance the result stage when it is empty or its transfer completes;
  // advance the input stage when it is empty or can move forward.
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_adv   = !in_valid_r || out_adv;
  assign in_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_adv) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_data_r <= in_data;
    end
  end

  mshc_codec u_codec (
    .req (in_data_r),
    .res (codec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid_r) begin
      out_data_r <= codec_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A failed parse never returns a mode id.
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> (out_data_r.mode_id_out == '0))
    else $error("mode id returned on failed parse");

  // A built header carries the flag, zero reserved bits, even overall parity
  // and no mode id or error.
  a_build_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.phr_out != '0) |->
      out_data_r.phr_out[0] && (out_data_r.phr_out[2:1] == 2'b00) &&
      !(^out_data_r.phr_out) && (out_data_r.status == ST_OK) &&
      (out_data_r.mode_id_out == '0))
    else $error("malformed built header");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status <= ST_BAD_PARITY))
    else $error("undefined status code");

  // A full input stage with a stalled result stage must hold off input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |-> in_stall)
    else $error("input accepted with both stages full");

endmodule

`default_nettype wire

/* verif/mode_switch_header_codec_tb.sv */
module mode_switch_header_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mshc_pkg::*;

  // Run shape
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned IDLE_PCT = 37;
  localparam int unsigned HOLD_AT = 250;      // issue count that starts the long hold-off
  localparam int unsigned HOLD_CYCLES = 160;  // receiver hold-off length in cycles
  localparam int unsigned QUIET_FROM = 450;   // no idling on either side in this window
  localparam int unsigned QUIET_TO = 620;
  localparam int unsigned DRAIN_CYCLES = 12;  // drain time, well past the two-stage pipeline
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  header_requests[$];   // requests waiting to be offered
  out_t outcomes_due[$];      // predicted results, oldest first
  out_t due_now;

  int unsigned issued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        quiet;

  mode_switch_header_codec DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Header arithmetic
  // ---------------------------------------------------------------------

  // BCH(15,11) remainder: header bit 0 is the top-degree term of the
  // dividend, bits 0-10 all enter (reserved bits included), then four
  // zero bits; long division by x^4+x+1.
  function automatic logic [3:0] bch_remainder(input logic [15:0] word);
    logic [14:0] dividend;
    dividend = '0;
    for (int i = 0; i < 11; i++) begin
      dividend[14-i] = word[i];
    end
    for (int k = 14; k >= 4; k--) begin
      if (dividend[k]) begin
        dividend = dividend ^ (15'h13 << (k - 4));
      end
    end
    return dividend[3:0];
  endfunction

  // Well-formed header: flag set, given id and reserved bits, checksum and
  // parity filled in.
  function automatic logic [15:0] make_header(input logic [7:0] id, input logic [1:0] rsv);
    logic [15:0] word;
    word = {5'b0, id, rsv, 1'b1};
    word[14:11] = bch_remainder(word);
    word[15] = ^word[14:0];
    return word;
  endfunction

  // Expected result of one request. Parse checks run in priority order:
  // length, flag, checksum, parity; the id comes back only when all pass.
  function automatic out_t header_outcome(input in_t req);
    out_t res;
    res = '0;
    res.status = ST_OK;
    if (req.req_type == REQ_BUILD) begin
      res.phr_out = make_header(req.new_mode_id, 2'b00);
    end else if (req.byte_count != HDR_BYTES) begin
      res.status = ST_BAD_LENGTH;
    end else if (!req.phr_in[0]) begin
      res.status = ST_FLAG_CLEAR;
    end else if (bch_remainder(req.phr_in) != req.phr_in[14:11]) begin
      res.status = ST_BAD_CSUM;
    end else if ((^req.phr_in[14:0]) != req.phr_in[15]) begin
      res.status = ST_BAD_PARITY;
    end else begin
      res.mode_id_out = req.phr_in[10:3];
    end
    return res;
  endfunction

  task automatic add_request(input logic kind, input logic [7:0] id, input logic [15:0] phr,
                             input logic [3:0] count);
    in_t req;
    req.req_type = kind;
    req.new_mode_id = id;
    req.phr_in = phr;
    req.byte_count = count;
    header_requests.push_back(req);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer queued requests, hold the payload while stalled, idle at
  // random except inside the quiet window. Record the expected result at
  // the transfer itself.
  // ---------------------------------------------------------------------
  assign quiet = (issued >= QUIET_FROM) && (issued < QUIET_TO);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcomes_due.push_back(header_outcome(in_data));
      end
      // Advance only when nothing is held; a stalled transfer keeps its payload.
      if (!in_valid || !in_stall) begin
        if (header_requests.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= header_requests.pop_front();
          in_valid <= 1'b1;
          issued <= issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long receiver hold-off, counted here: the sender keeps offering, so the
  // pipeline fills and the block has to stall its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && issued >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare every result transfer with the oldest prediction,
  // field by field; stall at random.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing due, phr_out", out_data.phr_out, 16'h0);
        end else begin
          due_now = outcomes_due.pop_front();
          if (out_data.phr_out !== due_now.phr_out) begin
            report_mismatch("phr_out", out_data.phr_out, due_now.phr_out);
          end
          if (out_data.mode_id_out !== due_now.mode_id_out) begin
            report_mismatch("mode_id_out", 16'(out_data.mode_id_out), 16'(due_now.mode_id_out));
          end
          if (out_data.status !== due_now.status) begin
            report_mismatch("status", 16'(out_data.status), 16'(due_now.status));
          end
        end
      end
      out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d results outstanding", $realtime, outcomes_due.size());
      $display("mode_switch_header_codec_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] word;
    int unsigned roll;
    int unsigned pick;

    // Directed: build extremes, every parse status, check priority.
    add_request(REQ_BUILD, 8'h00, 16'hFFFF, 4'hF);
    add_request(REQ_BUILD, 8'hFF, 16'h0000, 4'h0);
    add_request(REQ_BUILD, 8'hA5, 16'h5A5A, 4'h2);
    add_request(REQ_PARSE, 8'hFF, make_header(8'hFF, 2'b00), HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, make_header(8'h00, 2'b00), HDR_BYTES);
    add_request(REQ_PARSE, 8'h3C, make_header(8'h3C, 2'b11), HDR_BYTES);  // reserved bits set
    add_request(REQ_PARSE, 8'h00, make_header(8'h81, 2'b00), 4'h0);
    add_request(REQ_PARSE, 8'h00, make_header(8'h81, 2'b00), 4'h1);
    add_request(REQ_PARSE, 8'h00, make_header(8'h81, 2'b00), 4'h3);
    add_request(REQ_PARSE, 8'h00, make_header(8'h81, 2'b00), 4'hF);
    // length outranks a clear flag
    add_request(REQ_PARSE, 8'h00, 16'h0000, 4'h0);
    add_request(REQ_PARSE, 8'h00, 16'h0000, HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, make_header(8'h5A, 2'b00) ^ 16'h0001, HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, make_header(8'h5A, 2'b00) ^ 16'h0800, HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, make_header(8'h5A, 2'b01) ^ 16'h0004, HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, make_header(8'h5A, 2'b00) ^ 16'h8000, HDR_BYTES);
    // reserved bit flipped with parity patched: still a checksum failure
    add_request(REQ_PARSE, 8'h00, make_header(8'h5A, 2'b00) ^ 16'h8002, HDR_BYTES);
    add_request(REQ_PARSE, 8'h00, 16'hFFFF, HDR_BYTES);
    add_request(REQ_PARSE, 8'hFF, make_header(8'hC3, 2'b10), HDR_BYTES);

    // Random: builds, well-formed headers with random content, some damaged,
    // some with a random length, the rest raw noise.
    repeat (RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      word = make_header(8'($urandom), 2'($urandom));
      if (roll < 25) begin
        add_request(REQ_BUILD, 8'($urandom), 16'($urandom), 4'($urandom));
      end else if (roll < 60) begin
        add_request(REQ_PARSE, 8'($urandom), word, HDR_BYTES);
      end else if (roll < 78) begin
        pick = $urandom_range(15);
        word[pick] = ~word[pick];
        if ($urandom_range(1) == 1) begin
          pick = $urandom_range(15);
          word[pick] = ~word[pick];
        end
        add_request(REQ_PARSE, 8'($urandom), word, HDR_BYTES);
      end else if (roll < 88) begin
        add_request(REQ_PARSE, 8'($urandom), word, 4'($urandom));
      end else begin
        add_request(REQ_PARSE, 8'($urandom), 16'($urandom),
                    ($urandom_range(1) == 1) ? HDR_BYTES : 4'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to transfer and every result to come back.
    while (header_requests.size() != 0 || in_valid || outcomes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("mode_switch_header_codec_tb OK");
    end else begin
      $display("mode_switch_header_codec_tb NOT OK");
    end
    $finish;
  end

endmodule
